### src/efti_pkg.sv
// Shared widths, register indexes and reset values for the escape-time iterator.
package efti_pkg;

  localparam int COORD_W     = 32;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int ADD_W       = COORD_W + 1;
  localparam int RADIUS_W    = 30;
  localparam int JULIA_W     = 31;
  localparam int LIMIT_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int FRAC_BITS_DEF = 28;

  localparam logic [CFG_IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JRE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JIM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd4;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd256;

endpackage

### src/efti_cfg_if.sv
// Configuration write channel: register index and write data.
interface efti_cfg_if;
  import efti_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### src/efti_point_if.sv
// Point channel: one complex coordinate pair per beat.
interface efti_point_if;
  import efti_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_re;
  logic signed [COORD_W-1:0] point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink (input valid, input point_re, input point_im, output ready);
endinterface

### src/efti_result_if.sv
// Result channel: iteration count and escape flag per beat.
interface efti_result_if;
  import efti_pkg::*;

  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] iterations;
  logic               escaped;

  modport source (output valid, output iterations, output escaped, input ready);
  modport sink (input valid, input iterations, input escaped, output ready);
endinterface

### src/efti_mul.sv
// Shared signed multiplier with a registered product.
module efti_mul (
  input  logic                                  clk,
  input  logic signed [efti_pkg::COORD_W-1:0]   a,
  input  logic signed [efti_pkg::COORD_W-1:0]   b,
  output logic signed [efti_pkg::PROD_W-1:0]    p
);
  import efti_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### src/escape_time_fractal_iterator.sv
// Escape-time iterator for Mandelbrot and Julia points in signed fixed point.
// One point is taken at a time; the block is busy until its count is known. All
// products go through one registered 32x32 multiplier, so an iteration steps
// through update, real square with part test, imaginary square and magnitude test.
// Setup states form the squared radius and the products of the start value.
// The result is raised after the magnitude test ends an iteration by escape or by
// reaching the limit, or after the part test when a part alone exceeds the radius;
// the count is at most the limit. A zero limit goes from idle straight to the
// finish state. The result sits in an output register, so the next point is
// taken in the cycle the result is raised, while it waits; a point that finishes
// while an earlier result still waits holds until that beat leaves.
module escape_time_fractal_iterator #(
  parameter int FRAC_BITS = efti_pkg::FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  efti_cfg_if.sink      cfg,
  efti_point_if.sink    point,
  efti_result_if.source result
);
  import efti_pkg::*;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(64'd2 << FRAC_BITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RR   = 4'd1;
  localparam logic [3:0] S_PXX  = 4'd2;
  localparam logic [3:0] S_PYY  = 4'd3;
  localparam logic [3:0] S_PXY  = 4'd4;
  localparam logic [3:0] S_UPD  = 4'd5;
  localparam logic [3:0] S_SQX  = 4'd6;
  localparam logic [3:0] S_SQY  = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic                       kind;
  logic [RADIUS_W-1:0]        radius;
  logic signed [JULIA_W-1:0]  jre;
  logic signed [JULIA_W-1:0]  jim;
  logic [LIMIT_W-1:0]         limit;

  logic [3:0]                 state;
  logic signed [PROD_W-1:0]   x;
  logic signed [PROD_W-1:0]   y;
  logic signed [ADD_W-1:0]    ar;
  logic signed [ADD_W-1:0]    ai;
  logic signed [PROD_W-1:0]   xx;
  logic signed [PROD_W-1:0]   yy;
  logic [PROD_W-1:0]          rr;
  logic [LIMIT_W-1:0]         n;
  logic                       esc;
  logic                       out_valid;
  logic [LIMIT_W-1:0]         out_iter;
  logic                       out_esc;

  logic signed [COORD_W-1:0]  mul_a;
  logic signed [COORD_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;

  logic signed [PROD_W-1:0]   sq_diff;
  logic signed [PROD_W-1:0]   new_re;
  logic signed [PROD_W-1:0]   new_im;
  logic [PROD_W-1:0]          abs_x;
  logic [PROD_W-1:0]          abs_y;
  logic [PROD_W-1:0]          radius_ext;
  logic                       big;
  logic [PROD_W-1:0]          mag_sq;
  logic                       esc_sq;
  logic [LIMIT_W-1:0]         n_inc;

  efti_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind   <= 1'b0;
      radius <= RADIUS_RST;
      jre    <= '0;
      jim    <= '0;
      limit  <= LIMIT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_KIND:   kind   <= cfg.data[0];
        REG_RADIUS: radius <= cfg.data[RADIUS_W-1:0];
        REG_JRE:    jre    <= cfg.data[JULIA_W-1:0];
        REG_JIM:    jim    <= cfg.data[JULIA_W-1:0];
        REG_LIMIT:  limit  <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_RR: begin
        mul_a = COORD_W'(radius);
        mul_b = COORD_W'(radius);
      end
      S_PXX, S_SQX: begin
        mul_a = x[COORD_W-1:0];
        mul_b = x[COORD_W-1:0];
      end
      S_PYY, S_SQY: begin
        mul_a = y[COORD_W-1:0];
        mul_b = y[COORD_W-1:0];
      end
      S_PXY, S_CHK: begin
        mul_a = x[COORD_W-1:0];
        mul_b = y[COORD_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign sq_diff    = xx - yy;
  assign new_re     = (sq_diff >>> FRAC_BITS) + PROD_W'(ar);
  assign new_im     = (prod >>> (FRAC_BITS - 1)) + PROD_W'(ai);
  assign abs_x      = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
  assign abs_y      = y[PROD_W-1] ? PROD_W'(-y) : PROD_W'(y);
  assign radius_ext = PROD_W'(radius);
  assign big        = (abs_x > radius_ext) || (abs_y > radius_ext);
  assign mag_sq     = PROD_W'(xx) + PROD_W'(prod);
  assign esc_sq     = mag_sq > rr;
  assign n_inc      = n + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (point.valid) begin
            state <= (limit == '0) ? S_FIN : S_RR;
          end
        end
        S_RR:  state <= S_PXX;
        S_PXX: state <= S_PYY;
        S_PYY: state <= S_PXY;
        S_PXY: state <= S_UPD;
        S_UPD: state <= S_SQX;
        S_SQX: state <= big ? S_FIN : S_SQY;
        S_SQY: state <= S_CHK;
        S_CHK: begin
          if (esc_sq || (n_inc == limit)) begin
            state <= S_FIN;
          end else begin
            state <= S_UPD;
          end
        end
        S_FIN: begin
          if (!out_valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        n   <= '0;
        esc <= 1'b0;
        if (kind) begin
          x  <= PROD_W'(point.point_re);
          y  <= PROD_W'(point.point_im);
          ar <= ADD_W'(jre);
          ai <= ADD_W'(jim);
        end else begin
          x  <= '0;
          y  <= '0;
          ar <= -ADD_W'(point.point_re);
          ai <= -ADD_W'(point.point_im);
        end
      end
      S_PXX: rr <= PROD_W'(prod);
      S_PYY, S_SQY: xx <= prod;
      S_PXY: yy <= prod;
      S_UPD: begin
        x <= new_re;
        y <= new_im;
      end
      S_SQX: begin
        if (big) begin
          esc <= 1'b1;
        end
      end
      S_CHK: begin
        yy <= prod;
        if (esc_sq) begin
          esc <= 1'b1;
        end else begin
          n <= n_inc;
        end
      end
      S_FIN: begin
        if (!out_valid || result.ready) begin
          out_iter <= n;
          out_esc  <= esc;
        end
      end
      default: ;
    endcase
  end

  assign point.ready       = (state == S_IDLE);
  assign result.valid      = out_valid;
  assign result.iterations = out_iter;
  assign result.escaped    = out_esc;

endmodule

### src/efti_checker.sv
// Port-level checks on the escape-time iterator, bound to its top level.
module efti_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         point_valid,
  input logic                         point_ready,
  input logic                         result_valid,
  input logic                         result_ready,
  input logic [efti_pkg::LIMIT_W-1:0] iterations,
  input logic                         escaped
);
  import efti_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (point_valid && point_ready) |=> !point_ready)
    else $error("point taken while a point is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(point_valid && point_ready))
    else $error("result raised right after an accept");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(iterations) && $stable(escaped)))
    else $error("stalled result beat changed");

endmodule

bind escape_time_fractal_iterator efti_checker u_efti_checker (
  .clk          (clk),
  .rst          (rst),
  .point_valid  (point.valid),
  .point_ready  (point.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .iterations   (result.iterations),
  .escaped      (result.escaped)
);
